[sv/xed_pkg.sv]
// ============================================================================
// xed_pkg: shared types and constants for the XML entity decoder
// Holds the entity spellings, the job record that passes from the front part
// to the back part, and the queue head bundle.
// ============================================================================
package xed_pkg;

    localparam int BYTE_W          = 8;
    localparam int NUM_ENT         = 6;
    localparam int MAX_HELD        = 5;
    localparam int MAX_EMIT        = MAX_HELD + 1;
    localparam int LEN_W           = 3;
    localparam int ENT_W           = 3;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [BYTE_W-1:0] AMP_CHAR   = 8'h26;
    localparam logic [BYTE_W-1:0] LT_CHAR    = 8'h3c;
    localparam logic [BYTE_W-1:0] GT_CHAR    = 8'h3e;
    localparam logic [BYTE_W-1:0] QUOTE_CHAR = 8'h22;
    localparam logic [BYTE_W-1:0] APOS_CHAR  = 8'h27;

    // Entity codes
    localparam logic [ENT_W-1:0] ENT_AMP  = 3'd0;
    localparam logic [ENT_W-1:0] ENT_LT   = 3'd1;
    localparam logic [ENT_W-1:0] ENT_GT   = 3'd2;
    localparam logic [ENT_W-1:0] ENT_QUOT = 3'd3;
    localparam logic [ENT_W-1:0] ENT_APOS = 3'd4;
    localparam logic [ENT_W-1:0] ENT_NUM  = 3'd5;

    // Spelling is stored first character in the top byte, zero padded below.
    typedef struct packed {
        logic [MAX_EMIT*BYTE_W-1:0] text;
        logic [LEN_W-1:0]           len;
        logic [BYTE_W-1:0]          ch;
    } ent_t;

    typedef logic [MAX_EMIT-1:0][BYTE_W-1:0] emit_bytes_t;

    // One run of results: len bytes taken from bytes[0] upwards.
    typedef struct packed {
        emit_bytes_t      bytes;
        logic [LEN_W-1:0] len;
        logic             eot;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } q_head_t;

    function automatic ent_t ent_entry(input logic [ENT_W-1:0] idx);
        ent_t e;
        case (idx)
            ENT_AMP:  e = '{text: {"&amp;", 8'h00},  len: 3'd5, ch: AMP_CHAR};
            ENT_LT:   e = '{text: {"&lt;", 16'h0000}, len: 3'd4, ch: LT_CHAR};
            ENT_GT:   e = '{text: {"&gt;", 16'h0000}, len: 3'd4, ch: GT_CHAR};
            ENT_QUOT: e = '{text: "&quot;",          len: 3'd6, ch: QUOTE_CHAR};
            ENT_APOS: e = '{text: "&apos;",          len: 3'd6, ch: APOS_CHAR};
            ENT_NUM:  e = '{text: {"&#39;", 8'h00},  len: 3'd5, ch: APOS_CHAR};
            default:  e = '0;
        endcase
        return e;
    endfunction

endpackage

[sv/xml_entity_decoder_unit.sv]
// ============================================================================
// xml_entity_decoder_unit: streaming decoder for predefined XML entities
// Replaces &amp; &lt; &gt; &quot; &apos; and &#39; by their characters and
// passes every other byte through, flushing partial spellings literally.
// ============================================================================
//
//  Channel  Handshake               Payload                      Direction
//  -------  ----------------------  ---------------------------  ---------
//  text     text_valid/text_stall   in_byte, end_of_text         into block
//  char     char_valid/char_stall   out_byte, run_end, text_end  out of block
//
//  A text transfer is taken every cycle while the job queue has room; the
//  queue depth (QUEUE_DEPTH) sets how far the two sides may drift apart.
//  Results leave one per cycle while char is not stalled; an item causes
//  one result per byte of its job, and items that only extend a held prefix
//  cause none. With the back part idle, a result passes the queue slot and
//  then the output register before it is presented.
//  rst_n clears the held count, the queue pointers and the output valid.
//  A stall on char holds the output register; the queue fills, then text stalls.
//
module xml_entity_decoder_unit
#(
    parameter int QUEUE_DEPTH = xed_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       text_valid,
    output logic                       text_stall,
    input  logic [xed_pkg::BYTE_W-1:0] in_byte,
    input  logic                       end_of_text,
    output logic                       char_valid,
    input  logic                       char_stall,
    output logic [xed_pkg::BYTE_W-1:0] out_byte,
    output logic                       run_end,
    output logic                       text_end
);

    logic             accept;
    logic             push;
    logic             pop;
    logic             q_full;
    xed_pkg::job_t    job;
    xed_pkg::q_head_t head;

    // Stall the text side only when the queue has no free slot
    assign text_stall = q_full;
    assign accept     = text_valid && !q_full;

    // Front part: classify each byte against the held prefix
    xed_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .push        (push),
        .job         (job)
    );

    // Queue: decouple classification from result delivery
    xed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (job),
        .pop      (pop),
        .head     (head),
        .full     (q_full)
    );

    // Back part: advance through each job, one result per transfer
    xed_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .char_stall (char_stall),
        .char_valid (char_valid),
        .out_byte   (out_byte),
        .run_end    (run_end),
        .text_end   (text_end)
    );

endmodule

[sv/xed_front.sv]
// ============================================================================
// xed_front: byte classifier and held-prefix store
// Matches the held bytes plus the new byte against every entity spelling and
// turns each transfer into at most one job of one to six result bytes.
// ============================================================================
module xed_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [xed_pkg::BYTE_W-1:0] in_byte,
    input  logic                       end_of_text,
    output logic                       push,
    output xed_pkg::job_t              job
);

    logic [xed_pkg::BYTE_W-1:0] pend_reg [xed_pkg::MAX_HELD];
    logic [xed_pkg::LEN_W-1:0]  pend_cnt_reg;
    logic [xed_pkg::LEN_W-1:0]  pend_cnt_next;

    logic [xed_pkg::LEN_W-1:0]  cnt;
    logic [xed_pkg::LEN_W-1:0]  cand_len;
    xed_pkg::emit_bytes_t       cand;
    logic                       full_hit;
    logic                       pfx_hit;
    logic [xed_pkg::BYTE_W-1:0] full_ch;
    logic                       hold;
    logic                       restart_amp;

    // Build the candidate and compare it with every spelling
    always_comb
    begin
        xed_pkg::ent_t ent;
        logic          hit;
        cnt      = (pend_cnt_reg > xed_pkg::LEN_W'(xed_pkg::MAX_HELD)) ? '0 : pend_cnt_reg;
        cand_len = cnt + 3'd1;
        for (int i = 0; i < xed_pkg::MAX_HELD; i++)
        begin
            if (xed_pkg::LEN_W'(i) < cnt)
                cand[i] = pend_reg[i];
            else if (xed_pkg::LEN_W'(i) == cnt)
                cand[i] = in_byte;
            else
                cand[i] = '0;
        end
        cand[xed_pkg::MAX_EMIT-1] =
            (cnt == xed_pkg::LEN_W'(xed_pkg::MAX_HELD)) ? in_byte : '0;

        full_hit = 1'b0;
        pfx_hit  = 1'b0;
        full_ch  = '0;
        for (int e = 0; e < xed_pkg::NUM_ENT; e++)
        begin
            ent = xed_pkg::ent_entry(xed_pkg::ENT_W'(e));
            hit = (cand_len <= ent.len);
            for (int i = 0; i < xed_pkg::MAX_EMIT; i++)
            begin
                if ((xed_pkg::LEN_W'(i) < cand_len) &&
                    (cand[i] != ent.text[(xed_pkg::MAX_EMIT-1-i)*xed_pkg::BYTE_W +:
                                         xed_pkg::BYTE_W]))
                    hit = 1'b0;
            end
            if (hit && (cand_len == ent.len))
            begin
                if (!full_hit)
                    full_ch = ent.ch;
                full_hit = 1'b1;
            end
            if (hit && (cand_len < ent.len))
                pfx_hit = 1'b1;
        end
    end

    // Decide the job and the next held count
    always_comb
    begin
        hold        = !full_hit && pfx_hit &&
                      (cand_len <= xed_pkg::LEN_W'(xed_pkg::MAX_HELD));
        restart_amp = !full_hit && !hold && (in_byte == xed_pkg::AMP_CHAR);
        job.bytes   = cand;
        job.eot     = end_of_text;
        if (full_hit)
        begin
            job.bytes[0]  = full_ch;
            job.len       = 3'd1;
            pend_cnt_next = '0;
        end
        else if (hold)
        begin
            job.len       = end_of_text ? cand_len : '0;
            pend_cnt_next = cand_len;
        end
        else if (restart_amp)
        begin
            job.len       = end_of_text ? cand_len : cnt;
            pend_cnt_next = 3'd1;
        end
        else
        begin
            job.len       = cand_len;
            pend_cnt_next = '0;
        end
        if (end_of_text)
            pend_cnt_next = '0;
    end

    assign push = accept && (job.len != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_cnt_reg <= '0;
        else if (accept)
            pend_cnt_reg <= pend_cnt_next;
    end

    // Held bytes are read only below the count, so they need no reset
    always_ff @(posedge clk)
    begin
        if (accept && hold)
            pend_reg[cnt] <= in_byte;
        else if (accept && restart_amp)
            pend_reg[0] <= xed_pkg::AMP_CHAR;
    end

endmodule

[sv/xed_queue.sv]
// ============================================================================
// xed_queue: job queue between the front and back parts
// A small circular buffer of jobs; the head is presented with a valid flag.
// ============================================================================
module xed_queue
#(
    parameter int DEPTH = xed_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  xed_pkg::job_t     push_job,
    input  logic              pop,
    output xed_pkg::q_head_t  head,
    output logic              full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    xed_pkg::job_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.job   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

[sv/xed_back.sv]
// ============================================================================
// xed_back: result sequencer
// Walks the head job into the output register, one byte per cycle while the
// output is not stalled, and pops the job after its last byte.
// ============================================================================
module xed_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  xed_pkg::q_head_t           head,
    output logic                       pop,
    input  logic                       char_stall,
    output logic                       char_valid,
    output logic [xed_pkg::BYTE_W-1:0] out_byte,
    output logic                       run_end,
    output logic                       text_end
);

    logic [xed_pkg::LEN_W-1:0]  pos_reg;
    logic [xed_pkg::LEN_W-1:0]  pos_next;
    logic                       valid_reg;
    logic                       valid_next;
    logic [xed_pkg::BYTE_W-1:0] byte_reg;
    logic                       run_end_reg;
    logic                       text_end_reg;
    logic                       out_free;
    logic                       advance;
    logic                       last;

    assign out_free = !valid_reg || !char_stall;
    assign advance  = out_free && head.valid;
    assign last     = (pos_reg == (head.job.len - 3'd1));
    assign pop      = advance && last;

    always_comb
    begin
        pos_next   = pos_reg;
        valid_next = valid_reg;
        if (advance)
        begin
            pos_next   = last ? '0 : pos_reg + 3'd1;
            valid_next = 1'b1;
        end
        else if (out_free)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg     <= head.job.bytes[pos_reg];
            run_end_reg  <= last;
            text_end_reg <= last && head.job.eot;
        end
    end

    assign char_valid = valid_reg;
    assign out_byte   = byte_reg;
    assign run_end    = run_end_reg;
    assign text_end   = text_end_reg;

endmodule

[sv/xed_checker.sv]
// ============================================================================
// xed_checker: port-level checks for the XML entity decoder
// Watches the top-level ports and reports violations of output behaviour.
// ============================================================================
module xed_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       text_valid,
    input logic                       char_valid,
    input logic                       char_stall,
    input logic [xed_pkg::BYTE_W-1:0] out_byte,
    input logic                       run_end,
    input logic                       text_end
);

    // A stalled result holds its payload
    a_char_hold: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_stall |=> char_valid && $stable(out_byte) &&
                                     $stable(run_end) && $stable(text_end))
        else $error("stalled result changed");

    // The end of a string is always the end of a run
    a_text_end_run: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && text_end |-> run_end)
        else $error("text_end without run_end");

    // Nothing leaves straight after reset release
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !char_valid)
        else $error("result valid right after reset");

    // A result cannot appear straight after an idle, empty block
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(char_valid) && !$past(text_valid) && !$past(text_valid, 2) &&
        $past(rst_n, 2) |-> !char_valid)
        else $error("result without a preceding transfer");

endmodule

bind xml_entity_decoder_unit xed_checker u_xed_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .text_valid (text_valid),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .out_byte   (out_byte),
    .run_end    (run_end),
    .text_end   (text_end)
);

[tb/tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb: regression for the XML entity decoder
// Sends short directed strings and then a few hundred random bytes, most of
// them entity spellings, and checks every decoded character against a local
// model of the held-prefix decoder. The receiver stalls in bursts and once for
// a long stretch, so that the job queue fills up and the input stalls.
// ============================================================================

typedef struct {
    logic [xed_pkg::BYTE_W-1:0] out_byte;
    logic                       run_end;
    logic                       text_end;
} decoded_char_t;

class entity_decode_scoreboard;

    decoded_char_t              pending_chars[$];
    decoded_char_t              run_chars[$];
    logic [xed_pkg::BYTE_W-1:0] held_bytes[xed_pkg::MAX_HELD];
    int                         held_len;
    int                         errors;
    int                         checked;

    function new();
        foreach (held_bytes[i])
            held_bytes[i] = '0;
        held_len = 0;
        errors   = 0;
        checked  = 0;
    endfunction

    function string spelling(int code);
        case (code)
            xed_pkg::ENT_AMP:  return "&amp;";
            xed_pkg::ENT_LT:   return "&lt;";
            xed_pkg::ENT_GT:   return "&gt;";
            xed_pkg::ENT_QUOT: return "&quot;";
            xed_pkg::ENT_APOS: return "&apos;";
            xed_pkg::ENT_NUM:  return "&#39;";
            default:           return "";
        endcase
    endfunction

    function logic [xed_pkg::BYTE_W-1:0] entity_char(int code);
        case (code)
            xed_pkg::ENT_AMP:  return xed_pkg::AMP_CHAR;
            xed_pkg::ENT_LT:   return xed_pkg::LT_CHAR;
            xed_pkg::ENT_GT:   return xed_pkg::GT_CHAR;
            xed_pkg::ENT_QUOT: return xed_pkg::QUOTE_CHAR;
            default:           return xed_pkg::APOS_CHAR;
        endcase
    endfunction

    function int pending();
        return pending_chars.size();
    endfunction

    function void emit(logic [xed_pkg::BYTE_W-1:0] b);
        decoded_char_t r;
        r.out_byte = b;
        r.run_end  = 1'b0;
        r.text_end = 1'b0;
        run_chars.push_back(r);
    endfunction

    function void flush_held();
        for (int i = 0; i < held_len && i < xed_pkg::MAX_HELD; i++)
            emit(held_bytes[i]);
        held_len = 0;
    endfunction

    function void take_fresh(logic [xed_pkg::BYTE_W-1:0] c);
        if (c == xed_pkg::AMP_CHAR)
        begin
            held_bytes[0] = c;
            held_len      = 1;
        end
        else
            emit(c);
    endfunction

    // Work out the characters that one accepted byte releases.
    function void note_text(logic [xed_pkg::BYTE_W-1:0] c, logic eot);
        string                      s;
        int                         full;
        bit                         prefix;
        bit                         hit;
        int                         len;
        logic [xed_pkg::BYTE_W-1:0] cand;
        run_chars.delete();
        full   = -1;
        prefix = 1'b0;
        if (held_len > xed_pkg::MAX_HELD)
            held_len = 0;
        if (held_len == 0)
            take_fresh(c);
        else
        begin
            len = held_len + 1;
            for (int e = 0; e < xed_pkg::NUM_ENT; e++)
            begin
                s = spelling(e);
                if (s.len() >= len)
                begin
                    hit = 1'b1;
                    for (int i = 0; i < len; i++)
                    begin
                        cand = (i < held_len) ? held_bytes[i] : c;
                        if (s[i] != cand)
                            hit = 1'b0;
                    end
                    if (hit && s.len() == len && full < 0)
                        full = e;
                    else if (hit && s.len() > len)
                        prefix = 1'b1;
                end
            end
            if (full >= 0)
            begin
                held_len = 0;
                emit(entity_char(full));
            end
            else if (prefix && len <= xed_pkg::MAX_HELD)
            begin
                held_bytes[held_len] = c;
                held_len             = len;
            end
            else
            begin
                flush_held();
                take_fresh(c);
            end
        end
        if (eot)
            flush_held();
        if (run_chars.size() > 0)
        begin
            run_chars[run_chars.size()-1].run_end = 1'b1;
            if (eot)
                run_chars[run_chars.size()-1].text_end = 1'b1;
        end
        foreach (run_chars[i])
            pending_chars.push_back(run_chars[i]);
    endfunction

    task report_mismatch(string what);
        $display("MISMATCH at %0t, char %0d: %s", $time, checked, what);
        errors++;
    endtask

    task check_char(logic [xed_pkg::BYTE_W-1:0] b, logic re, logic te);
        decoded_char_t want;
        if (pending_chars.size() == 0)
        begin
            report_mismatch($sformatf("unexpected char 0x%02h", b));
            return;
        end
        want = pending_chars.pop_front();
        if (b !== want.out_byte)
            report_mismatch($sformatf("out_byte 0x%02h, want 0x%02h", b, want.out_byte));
        if (re !== want.run_end)
            report_mismatch($sformatf("run_end %b, want %b", re, want.run_end));
        if (te !== want.text_end)
            report_mismatch($sformatf("text_end %b, want %b", te, want.text_end));
        checked++;
    endtask

    task check_leftover();
        if (pending_chars.size() != 0)
            report_mismatch($sformatf("%0d chars never arrived", pending_chars.size()));
    endtask

endclass

module tb;

    // Random part size and the points at which the run changes character.
    localparam int RANDOM_ITEMS = 405;
    localparam int HOLD_AT      = 120;
    localparam int DRAIN_AT     = 240;
    localparam int QUIET_AT     = 340;
    localparam int LONG_HOLD    = 300;
    localparam int TAIL_CYCLES  = 20;

    logic                       clk;
    logic                       rst_n;
    logic                       text_valid;
    logic                       text_stall;
    logic [xed_pkg::BYTE_W-1:0] in_byte;
    logic                       end_of_text;
    logic                       char_valid;
    logic                       char_stall;
    logic [xed_pkg::BYTE_W-1:0] out_byte;
    logic                       run_end;
    logic                       text_end;

    entity_decode_scoreboard sb;

    int bytes_sent;
    bit quiet;          // no idling on either side once set
    bit long_hold_req;  // ask the receiver for one long stall

    xml_entity_decoder_unit i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_stall  (text_stall),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .out_byte    (out_byte),
        .run_end     (run_end),
        .text_end    (text_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs; far beyond the slowest correct run.
    initial
    begin
        #2ms;
        $display("xml_entity_decoder_unit regression: fail");
        $finish;
    end

    // Offer one byte and hold it until the transfer happens, then note it
    // with the model and perhaps drop valid for a short random gap.
    task automatic send_text(input logic [xed_pkg::BYTE_W-1:0] b, input logic eot);
        text_valid  <= 1'b1;
        in_byte     <= b;
        end_of_text <= eot;
        do
            @(posedge clk);
        while (text_stall);
        sb.note_text(b, eot);
        bytes_sent++;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            text_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Send a whole string; the end flag goes only on its final byte.
    task automatic send_string(input string s, input logic eot);
        for (int i = 0; i < s.len(); i++)
            send_text(s[i], eot && (i == s.len() - 1));
    endtask

    // Random end flag: mostly off, so strings run for a while.
    function automatic logic rand_eot();
        return ($urandom_range(0, 11) == 0);
    endfunction

    // One random token: a whole entity, a broken prefix, a lone ampersand, or a raw byte.
    task automatic send_random_token();
        int    kind;
        int    code;
        int    cut;
        string s;
        kind = $urandom_range(0, 9);
        code = $urandom_range(0, xed_pkg::NUM_ENT - 1);
        s    = sb.spelling(code);
        if (kind < 5)
        begin
            for (int i = 0; i < s.len(); i++)
                send_text(s[i], rand_eot());
        end
        else if (kind < 7)
        begin
            cut = $urandom_range(1, s.len() - 1);
            for (int i = 0; i < cut; i++)
                send_text(s[i], rand_eot());
            send_text(xed_pkg::BYTE_W'($urandom_range(0, 255)), rand_eot());
        end
        else if (kind < 8)
            send_text(xed_pkg::AMP_CHAR, rand_eot());
        else
            send_text(xed_pkg::BYTE_W'($urandom_range(0, 255)), rand_eot());
    endtask

    // Drop valid and wait for every outstanding character.
    task automatic drain_chars();
        text_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Receiver: stall in short random bursts, or for one long stretch when
    // asked, counting the cycles here. One stall assignment per edge.
    initial
    begin
        int hold_left;
        int burst_left;
        hold_left  = 0;
        burst_left = 0;
        char_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                char_stall <= 1'b1;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                char_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                burst_left = $urandom_range(1, 6) - 1;
                char_stall <= 1'b1;
            end
            else
                char_stall <= 1'b0;
        end
    end

    // Check every character transfer against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && char_valid && !char_stall)
            sb.check_char(out_byte, run_end, text_end);
    end

    initial
    begin
        bit hold_done;
        bit drain_done;
        sb            = new();
        bytes_sent    = 0;
        quiet         = 1'b0;
        long_hold_req = 1'b0;
        hold_done     = 1'b0;
        drain_done    = 1'b0;
        rst_n       <= 1'b0;
        text_valid  <= 1'b0;
        in_byte     <= '0;
        end_of_text <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: complete entities, an ampersand that breaks a prefix and
        // starts a new one, a partial spelling flushed at the end of a string,
        // a zero byte, an all-ones byte, and a lone ampersand at the end.
        send_string("&lt;", 1'b0);
        send_string("&#39;", 1'b0);
        send_string("&a&gt;", 1'b0);
        send_string("&quo", 1'b1);
        send_text(8'h00, 1'b0);
        send_text(8'hff, 1'b1);
        send_string("&", 1'b1);
        drain_chars();

        // Random part: mostly well-formed entities with noise between them.
        bytes_sent = 0;
        while (bytes_sent < RANDOM_ITEMS)
        begin
            if (!hold_done && bytes_sent >= HOLD_AT)
            begin
                hold_done     = 1'b1;
                long_hold_req = 1'b1;
            end
            if (!drain_done && bytes_sent >= DRAIN_AT)
            begin
                drain_done = 1'b1;
                drain_chars();
            end
            if (bytes_sent >= QUIET_AT)
                quiet = 1'b1;
            send_random_token();
        end

        // Flush whatever prefix is still held so every byte comes out.
        send_text(xed_pkg::BYTE_W'($urandom_range(0, 255)), 1'b1);
        drain_chars();
        repeat (TAIL_CYCLES) @(posedge clk);
        sb.check_leftover();
        if (sb.errors == 0)
            $display("xml_entity_decoder_unit regression: pass");
        else
            $display("xml_entity_decoder_unit regression: fail");
        $finish;
    end

endmodule

[filelist.f]
sv/xed_pkg.sv
sv/xed_front.sv
sv/xed_queue.sv
sv/xed_back.sv
sv/xml_entity_decoder_unit.sv
sv/xed_checker.sv
tb/tb.sv
